/* sv/lr_pkg.sv */
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared constants, command codes and register map for the line engine.
// ----------------------------------------------------------------------------
package lr_pkg;

  // Default coordinate width and the width of the screen size registers.
  localparam int COORD_BITS_DEF = 12;
  localparam int DIM_BITS       = 11;
  localparam int COLOR_BITS     = 8;

  // Reset values of the screen size registers.
  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 11'd800;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 11'd600;

  // Configuration port layout.
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Queue depths between the parts of the engine.
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  // Item command codes.
  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_code_t;

  // Screen size as seen by the back end.
  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
  } dim_cfg_t;

  // Width of a classified command word for a given coordinate width.
  function automatic int cmd_bits(input int n);
    return 7 * n + 12;
  endfunction

  // Width of a result word for a given coordinate width.
  function automatic int res_bits(input int n);
    return 2 * n + 11;
  endfunction

endpackage

/* sv/lr_fifo.sv */
// ----------------------------------------------------------------------------
// Line rasterizer queue
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module lr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // Storage is written at the write pointer.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/lr_cfg.sv */
// ----------------------------------------------------------------------------
// Line rasterizer configuration registers
// APB-style access to the screen width and height registers.
// ----------------------------------------------------------------------------
module lr_cfg import lr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output dim_cfg_t                 dims
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dims.width  <= WIDTH_RESET;
      dims.height <= HEIGHT_RESET;
    end else if (wr_en) begin
      if (reg_sel == REG_WIDTH) begin
        dims.width <= pwdata[DIM_BITS-1:0];
      end else begin
        dims.height <= pwdata[DIM_BITS-1:0];
      end
    end
  end

  // Read data is a plain select of the addressed register.
  always_comb begin
    prdata = '0;
    if (reg_sel == REG_HEIGHT) begin
      prdata[DIM_BITS-1:0] = dims.height;
    end else begin
      prdata[DIM_BITS-1:0] = dims.width;
    end
  end

endmodule

/* sv/lr_front.sv */
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Accepts items, classifies them and precomputes line setup for loads.
// ----------------------------------------------------------------------------
module lr_front import lr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 cmd,
  input  logic signed [COORD_BITS-1:0]         start_x,
  input  logic signed [COORD_BITS-1:0]         start_y,
  input  logic signed [COORD_BITS-1:0]         stop_x,
  input  logic signed [COORD_BITS-1:0]         stop_y,
  input  logic [COLOR_BITS-1:0]                pen_color,
  output logic                                 cmd_push,
  output logic [cmd_bits(COORD_BITS)-1:0]      cmd_word,
  input  logic                                 cmd_full
);

  typedef struct packed {
    cmd_code_t                      code;
    logic signed [COORD_BITS-1:0]   start_x;
    logic signed [COORD_BITS-1:0]   start_y;
    logic signed [COORD_BITS-1:0]   end_x;
    logic signed [COORD_BITS-1:0]   end_y;
    logic [COORD_BITS-1:0]          dist_x;
    logic [COORD_BITS-1:0]          dist_y;
    logic                           step_x_neg;
    logic                           step_y_neg;
    logic signed [COORD_BITS:0]     err;
    logic [COLOR_BITS-1:0]          color;
  } cmd_t;

  cmd_t                       word;
  logic signed [COORD_BITS:0] diff_x;
  logic signed [COORD_BITS:0] diff_y;
  logic                       x_up;
  logic                       y_up;
  logic [COORD_BITS:0]        abs_x;
  logic [COORD_BITS:0]        abs_y;

  // Handshake passes straight through to the command queue.
  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;

  // Absolute deltas and step directions of the new line.
  always_comb begin
    diff_x = {stop_x[COORD_BITS-1], stop_x} - {start_x[COORD_BITS-1], start_x};
    diff_y = {stop_y[COORD_BITS-1], stop_y} - {start_y[COORD_BITS-1], start_y};
    x_up   = (start_x < stop_x);
    y_up   = (start_y < stop_y);
    abs_x  = x_up ? diff_x : -diff_x;
    abs_y  = y_up ? diff_y : -diff_y;
  end

  // Build the classified command word.
  always_comb begin
    word.code       = cmd_code_t'(cmd);
    word.start_x    = start_x;
    word.start_y    = start_y;
    word.end_x      = stop_x;
    word.end_y      = stop_y;
    word.dist_x     = abs_x[COORD_BITS-1:0];
    word.dist_y     = abs_y[COORD_BITS-1:0];
    word.step_x_neg = !x_up;
    word.step_y_neg = !y_up;
    word.err        = $signed({1'b0, abs_x[COORD_BITS-1:0]})
                    - $signed({1'b0, abs_y[COORD_BITS-1:0]});
    word.color      = pen_color;
  end

  assign cmd_word = word;

endmodule

/* sv/lr_back.sv */
// ----------------------------------------------------------------------------
// Line rasterizer back end
// Holds the running line and takes one Bresenham step per advance while it runs.
// ----------------------------------------------------------------------------
module lr_back import lr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dim_cfg_t                             dims,
  input  logic                                 cmd_empty,
  input  logic [cmd_bits(COORD_BITS)-1:0]      cmd_word,
  output logic                                 cmd_pop,
  input  logic                                 res_full,
  output logic                                 res_push,
  output logic [res_bits(COORD_BITS)-1:0]      res_word
);

  typedef struct packed {
    cmd_code_t                      code;
    logic signed [COORD_BITS-1:0]   start_x;
    logic signed [COORD_BITS-1:0]   start_y;
    logic signed [COORD_BITS-1:0]   end_x;
    logic signed [COORD_BITS-1:0]   end_y;
    logic [COORD_BITS-1:0]          dist_x;
    logic [COORD_BITS-1:0]          dist_y;
    logic                           step_x_neg;
    logic                           step_y_neg;
    logic signed [COORD_BITS:0]     err;
    logic [COLOR_BITS-1:0]          color;
  } cmd_t;

  typedef struct packed {
    logic                           valid_res;
    logic [COORD_BITS-1:0]          pixel_x;
    logic [COORD_BITS-1:0]          pixel_y;
    logic [COLOR_BITS-1:0]          pixel_color;
    logic                           visible;
    logic                           last;
  } res_t;

  localparam int VW = COORD_BITS + DIM_BITS;

  cmd_t                         cw;
  res_t                         res;

  // Line state. The error term can reach one and a half times the larger
  // delta during a shallow line, so it carries two bits beyond the coordinates.
  logic signed [COORD_BITS-1:0] cur_x, cur_y, end_x, end_y;
  logic [COORD_BITS-1:0]        dist_x, dist_y;
  logic                         step_x_neg, step_y_neg;
  logic signed [COORD_BITS+1:0] error_term;
  logic [COLOR_BITS-1:0]        line_color;
  logic                         busy;

  logic signed [COORD_BITS-1:0] cur_x_next, cur_y_next, end_x_next, end_y_next;
  logic [COORD_BITS-1:0]        dist_x_next, dist_y_next;
  logic                         step_x_neg_next, step_y_neg_next;
  logic signed [COORD_BITS+1:0] error_term_next;
  logic [COLOR_BITS-1:0]        line_color_next;

  logic                         go;
  logic                         is_load;
  logic                         emit;
  logic                         fin;
  logic signed [COORD_BITS+2:0] err_ext;
  logic signed [COORD_BITS+2:0] e2;
  logic signed [COORD_BITS+2:0] dx_ext;
  logic signed [COORD_BITS+2:0] dy_ext;
  logic signed [COORD_BITS+2:0] err_sum;
  logic                         move_x;
  logic                         move_y;

  assign cw       = cmd_word;
  assign go       = !cmd_empty && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;
  assign is_load  = (cw.code == CMD_LOAD);
  assign emit     = is_load || busy;

  // One Bresenham step: both tests use the error value from before the step.
  always_comb begin
    err_ext = {error_term[COORD_BITS+1], error_term};
    e2      = {error_term, 1'b0};
    dx_ext  = $signed({3'b000, dist_x});
    dy_ext  = $signed({3'b000, dist_y});
    move_x  = (e2 > -dy_ext);
    move_y  = (e2 < dx_ext);
    err_sum = err_ext - (move_x ? dy_ext : '0) + (move_y ? dx_ext : '0);
  end

  // Next line state for a load or for an advance.
  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    end_x_next      = end_x;
    end_y_next      = end_y;
    dist_x_next     = dist_x;
    dist_y_next     = dist_y;
    step_x_neg_next = step_x_neg;
    step_y_neg_next = step_y_neg;
    error_term_next = error_term;
    line_color_next = line_color;
    if (is_load) begin
      cur_x_next      = cw.start_x;
      cur_y_next      = cw.start_y;
      end_x_next      = cw.end_x;
      end_y_next      = cw.end_y;
      dist_x_next     = cw.dist_x;
      dist_y_next     = cw.dist_y;
      step_x_neg_next = cw.step_x_neg;
      step_y_neg_next = cw.step_y_neg;
      error_term_next = {cw.err[COORD_BITS], cw.err};
      line_color_next = cw.color;
    end else begin
      error_term_next = err_sum[COORD_BITS+1:0];
      if (move_x) begin
        cur_x_next = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (move_y) begin
        cur_y_next = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      end
    end
  end

  // Result for the emitted pixel; an advance while idle gives all zeros.
  always_comb begin
    fin = (cur_x_next == end_x_next) && (cur_y_next == end_y_next);
    res = '0;
    if (emit) begin
      res.valid_res   = 1'b1;
      res.pixel_x     = cur_x_next;
      res.pixel_y     = cur_y_next;
      res.pixel_color = line_color_next;
      res.visible     = !cur_x_next[COORD_BITS-1] && !cur_y_next[COORD_BITS-1]
                     && ({{DIM_BITS{1'b0}}, cur_x_next} < VW'(dims.width))
                     && ({{DIM_BITS{1'b0}}, cur_y_next} < VW'(dims.height));
      res.last        = fin;
    end
  end

  assign res_word = res;

  // Line state registers.
  always_ff @(posedge clk) begin
    if (go && emit) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      end_x      <= end_x_next;
      end_y      <= end_y_next;
      dist_x     <= dist_x_next;
      dist_y     <= dist_y_next;
      step_x_neg <= step_x_neg_next;
      step_y_neg <= step_y_neg_next;
      error_term <= error_term_next;
      line_color <= line_color_next;
    end
  end

  // The line is running until its endpoint has been emitted.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go && emit) begin
      busy <= !fin;
    end
  end

`ifndef SYNTHESIS
  // Emitting the endpoint ends the line.
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    go && res.valid_res && res.last |=> !busy)
    else $error("line still running after its endpoint");

  // An advance with no running line returns an empty result.
  a_idle_advance: assert property (@(posedge clk) disable iff (rst)
    go && !is_load && !busy |-> res_push && !res.valid_res)
    else $error("advance while idle produced a pixel");

  // The error term stays within twice the deltas while a line runs.
  a_err_bounds: assert property (@(posedge clk) disable iff (rst)
    busy |-> (err_ext >= -(dy_ext + dy_ext)) && (err_ext <= dx_ext + dx_ext))
    else $error("error term out of range");

  // A non-load step moves x by at most one.
  a_unit_step: assert property (@(posedge clk) disable iff (rst)
    go && !is_load && busy |=> ((cur_x - $past(cur_x)) == '0
      || (cur_x - $past(cur_x)) == COORD_BITS'(1)
      || (cur_x - $past(cur_x)) == '1))
    else $error("x moved by more than one pixel");
`endif

endmodule

/* sv/line_rasterizer_top.sv */
// Path: an accepted item is written into the command queue, stepped by the back end
// and written into the result queue, whose oldest entry drives the result ports.
// Throughput: one item per cycle while items wait and the result queue has room;
// error update, coordinate step and endpoint compare are in one register stage.
// Reset (rst, synchronous): empties both queues, ends any running line and sets
// the screen to 800 by 600.
// ----------------------------------------------------------------------------
// Line rasterizer top level
// Pull-style Bresenham line engine with queue interfaces and APB registers.
// ----------------------------------------------------------------------------
module line_rasterizer_top import lr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0]     pwdata,
  output logic [APB_DATA_BITS-1:0]     prdata,
  output logic                         pready,
  // Input items
  input  logic                         push,
  output logic                         full,
  input  logic                         cmd,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] stop_x,
  input  logic signed [COORD_BITS-1:0] stop_y,
  input  logic [COLOR_BITS-1:0]        pen_color,
  // Result items
  output logic                         empty,
  input  logic                         pop,
  output logic                         valid_res,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0]        pixel_color,
  output logic                         visible,
  output logic                         last
);

  localparam int CW = cmd_bits(COORD_BITS);
  localparam int RW = res_bits(COORD_BITS);

  typedef struct packed {
    logic                           valid_res;
    logic [COORD_BITS-1:0]          pixel_x;
    logic [COORD_BITS-1:0]          pixel_y;
    logic [COLOR_BITS-1:0]          pixel_color;
    logic                           visible;
    logic                           last;
  } res_t;

  dim_cfg_t         dims;
  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CW-1:0]    cmd_wdata, cmd_rdata;
  logic             res_push, res_full;
  logic [RW-1:0]    res_wdata, res_rdata;
  res_t             res;

  // Configuration registers.
  lr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims    (dims)
  );

  // Front end: classify items and set up new lines.
  lr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .start_x   (start_x),
    .start_y   (start_y),
    .stop_x    (stop_x),
    .stop_y    (stop_y),
    .pen_color (pen_color),
    .cmd_push  (cmd_push),
    .cmd_word  (cmd_wdata),
    .cmd_full  (cmd_full)
  );

  // Command queue between front and back.
  lr_fifo #(.WIDTH(CW), .DEPTH(CMD_QUEUE_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  // Back end: Bresenham stepping.
  lr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .dims      (dims),
    .cmd_empty (cmd_empty),
    .cmd_word  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_word  (res_wdata)
  );

  // Result queue toward the consumer.
  lr_fifo #(.WIDTH(RW), .DEPTH(RES_QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  // Unpack the oldest result onto the ports.
  assign res         = res_rdata;
  assign valid_res   = res.valid_res;
  assign pixel_x     = res.pixel_x;
  assign pixel_y     = res.pixel_y;
  assign pixel_color = res.pixel_color;
  assign visible     = res.visible;
  assign last        = res.last;

endmodule

/* bench/line_rasterizer_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line rasterizer top level testbench
// Sends load and advance items through the push/full queue and pops pixels
// with random stalls. Each pixel is checked against a Bresenham line tracker
// kept in the bench or typed in the table. Screen size registers are rewritten
// over the APB port between phases, including zero and both extremes, and read back.
// ----------------------------------------------------------------------------
module line_rasterizer_top_test;
  import lr_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int COORD_MIN = -(2 ** (CB - 1));
  localparam int COORD_MAX = 2 ** (CB - 1) - 1;
  localparam logic [APB_ADDR_BITS-1:0] WIDTH_ADDR  = {REG_WIDTH, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] HEIGHT_ADDR = {REG_HEIGHT, 2'b00};
  localparam int PHASE_ITEMS = 220;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    cmd_code_t             cmd;
    logic signed [CB-1:0]  sx;
    logic signed [CB-1:0]  sy;
    logic signed [CB-1:0]  ex;
    logic signed [CB-1:0]  ey;
    logic [COLOR_BITS-1:0] color;
  } line_item_t;

  typedef struct {
    logic                  valid;
    logic signed [CB-1:0]  x;
    logic signed [CB-1:0]  y;
    logic [COLOR_BITS-1:0] color;
    logic                  vis;
    logic                  fin;
  } pixel_t;

  typedef struct {
    line_item_t it;
    bit         typed;
    pixel_t     px;
  } stim_row_t;

  // Clock, reset and the ports of the block.
  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic cmd = CMD_LOAD;
  logic signed [CB-1:0] start_x = '0;
  logic signed [CB-1:0] start_y = '0;
  logic signed [CB-1:0] stop_x = '0;
  logic signed [CB-1:0] stop_y = '0;
  logic [COLOR_BITS-1:0] pen_color = '0;
  logic empty;
  logic pop = 1'b0;
  logic valid_res;
  logic signed [CB-1:0] pixel_x;
  logic signed [CB-1:0] pixel_y;
  logic [COLOR_BITS-1:0] pixel_color;
  logic visible;
  logic last;

  line_rasterizer_top #(.COORD_BITS(CB)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .cmd(cmd),
    .start_x(start_x), .start_y(start_y), .stop_x(stop_x), .stop_y(stop_y),
    .pen_color(pen_color),
    .empty(empty), .pop(pop), .valid_res(valid_res),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
    .visible(visible), .last(last)
  );

  // Line tracker state and the screen size it assumes.
  int ln_x = 0, ln_y = 0, ln_end_x = 0, ln_end_y = 0;
  int ln_dx = 0, ln_dy = 0, ln_err = 0;
  bit ln_x_neg = 1'b0, ln_y_neg = 1'b0, line_busy = 1'b0;
  logic [COLOR_BITS-1:0] ln_color = '0;
  int scr_width = WIDTH_RESET;
  int scr_height = HEIGHT_RESET;

  pixel_t pending_pixels[$];
  pixel_t popped_want;
  pixel_t no_pixel = '{default: 0};
  stim_row_t directed[$];
  int mismatch_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endfunction

  // Bresenham step: returns the pixel that one item produces and updates the line.
  function automatic pixel_t trace_pixel(input line_item_t it);
    pixel_t px;
    int e2;
    px = '{default: 0};
    if (it.cmd == CMD_LOAD) begin
      ln_x = it.sx;
      ln_y = it.sy;
      ln_end_x = it.ex;
      ln_end_y = it.ey;
      ln_dx = (ln_end_x > ln_x) ? ln_end_x - ln_x : ln_x - ln_end_x;
      ln_dy = (ln_end_y > ln_y) ? ln_end_y - ln_y : ln_y - ln_end_y;
      ln_x_neg = !(ln_x < ln_end_x);
      ln_y_neg = !(ln_y < ln_end_y);
      ln_err = ln_dx - ln_dy;
      ln_color = it.color;
    end else if (line_busy) begin
      // Both tests use the error value from before the step.
      e2 = 2 * ln_err;
      if (e2 > -ln_dy) begin
        ln_err -= ln_dy;
        ln_x += ln_x_neg ? -1 : 1;
      end
      if (e2 < ln_dx) begin
        ln_err += ln_dx;
        ln_y += ln_y_neg ? -1 : 1;
      end
    end
    // An advance while idle leaves the all-zero pixel.
    if (it.cmd == CMD_LOAD || line_busy) begin
      px.valid = 1'b1;
      px.x = ln_x[CB-1:0];
      px.y = ln_y[CB-1:0];
      px.color = ln_color;
      px.vis = ln_x >= 0 && ln_x < scr_width && ln_y >= 0 && ln_y < scr_height;
      px.fin = (ln_x == ln_end_x) && (ln_y == ln_end_y);
      line_busy = !px.fin;
    end
    return px;
  endfunction

  // Result side: random pop stalls and the check of each popped pixel.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          note_mismatch($sformatf("pixel with nothing expected: v=%0b x=%0d y=%0d",
                                  valid_res, pixel_x, pixel_y));
        end else begin
          popped_want = pending_pixels.pop_front();
          if (valid_res !== popped_want.valid || pixel_x !== popped_want.x ||
              pixel_y !== popped_want.y || pixel_color !== popped_want.color ||
              visible !== popped_want.vis || last !== popped_want.fin)
            note_mismatch($sformatf(
              "expected v=%0b x=%0d y=%0d c=%0d vis=%0b last=%0b, got v=%0b x=%0d y=%0d c=%0d vis=%0b last=%0b",
              popped_want.valid, popped_want.x, popped_want.y, popped_want.color,
              popped_want.vis, popped_want.fin, valid_res, pixel_x, pixel_y,
              pixel_color, visible, last));
        end
      end
      pop <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Push one item, waiting out full; the expected pixel is queued on acceptance.
  task automatic send_item(input line_item_t it, input bit typed, input pixel_t typed_px);
    pixel_t px;
    if (send_gap_pct > 0) begin
      while ($urandom_range(99) < send_gap_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push <= 1'b1;
    cmd <= it.cmd;
    start_x <= it.sx;
    start_y <= it.sy;
    stop_x <= it.ex;
    stop_y <= it.ey;
    pen_color <= it.color;
    @(posedge clk);
    while (full) @(posedge clk);
    px = trace_pixel(it);
    pending_pixels.push_back(typed ? typed_px : px);
  endtask

  // Hold off the sender until every pixel has come back.
  task automatic drain();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_reg(input logic [APB_ADDR_BITS-1:0] addr);
    int want;
    want = (addr == WIDTH_ADDR) ? scr_width : scr_height;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DATA_BITS'(want))
      note_mismatch($sformatf("register at %0d reads %0d, expected %0d", addr, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr, input int value);
    logic [APB_DATA_BITS-1:0] wdata;
    // Upper bits carry noise; only the low bits are kept by the register.
    wdata = $urandom;
    wdata[DIM_BITS-1:0] = value[DIM_BITS-1:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == WIDTH_ADDR) scr_width = wdata[DIM_BITS-1:0];
    else scr_height = wdata[DIM_BITS-1:0];
    @(posedge clk);
    check_reg(addr);
  endtask

  function automatic void add_row(input cmd_code_t c, input int sx, input int sy,
                                  input int ex, input int ey, input int col,
                                  input bit typed = 1'b0, input bit v = 1'b0,
                                  input int px = 0, input int py = 0, input int pcol = 0,
                                  input bit vis = 1'b0, input bit fin = 1'b0);
    stim_row_t r;
    r.it.cmd = c;
    r.it.sx = sx[CB-1:0];
    r.it.sy = sy[CB-1:0];
    r.it.ex = ex[CB-1:0];
    r.it.ey = ey[CB-1:0];
    r.it.color = col[COLOR_BITS-1:0];
    r.typed = typed;
    r.px.valid = v;
    r.px.x = px[CB-1:0];
    r.px.y = py[CB-1:0];
    r.px.color = pcol[COLOR_BITS-1:0];
    r.px.vis = vis;
    r.px.fin = fin;
    directed.push_back(r);
  endfunction

  // Directed table, for an 800 by 600 screen. Rows with a typed pixel are
  // obvious by hand; the others go through the tracker.
  function automatic void build_directed();
    // Advance straight after reset gives the empty pixel.
    add_row(CMD_ADVANCE, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0);
    // Single-point line ends at once and the engine goes idle.
    add_row(CMD_LOAD, 0, 0, 0, 0, 255, 1'b1, 1, 0, 0, 255, 1, 1);
    add_row(CMD_ADVANCE, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0);
    // Longest diagonal, corner to corner.
    add_row(CMD_LOAD, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0,
            1'b1, 1, COORD_MIN, COORD_MIN, 0, 0, 0);
    repeat (2) add_row(CMD_ADVANCE, 0, 0, 0, 0, 0);
    // Load while busy drops the running line.
    add_row(CMD_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 170,
            1'b1, 1, COORD_MAX, COORD_MAX, 170, 0, 1);
    add_row(CMD_ADVANCE, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0);
    // Last visible pixel, then one step off the screen corner.
    add_row(CMD_LOAD, 799, 599, 800, 600, 85, 1'b1, 1, 799, 599, 85, 1, 0);
    add_row(CMD_ADVANCE, 0, 0, 0, 0, 0);
    // Shallow line stepping toward negative x.
    add_row(CMD_LOAD, 5, 0, 0, 3, 1);
    repeat (5) add_row(CMD_ADVANCE, 0, 0, 0, 0, 0);
    // Vertical line starting above the screen.
    add_row(CMD_LOAD, 0, -3, 0, 3, 2, 1'b1, 1, 0, -3, 2, 0, 0);
    repeat (3) add_row(CMD_ADVANCE, 0, 0, 0, 0, 0);
    // Negative x is off screen even though it is a single point.
    add_row(CMD_LOAD, -1, 0, -1, 0, 128, 1'b1, 1, -1, 0, 128, 0, 1);
    // Anti-diagonal from the bottom edge.
    add_row(CMD_LOAD, 0, COORD_MAX, COORD_MAX, 0, 64, 1'b1, 1, 0, COORD_MAX, 64, 0, 0);
    repeat (2) add_row(CMD_ADVANCE, 0, 0, 0, 0, 0);
  endfunction

  function automatic line_item_t random_item(input cmd_code_t c);
    line_item_t it;
    it.cmd = c;
    it.sx = CB'($urandom);
    it.sy = CB'($urandom);
    it.ex = CB'($urandom);
    it.ey = CB'($urandom);
    it.color = COLOR_BITS'($urandom);
    return it;
  endfunction

  // Start coordinate: extremes, screen edge or anywhere.
  function automatic logic signed [CB-1:0] pick_coord(input int lim);
    int v;
    case ($urandom_range(9))
      0: v = COORD_MIN;
      1: v = COORD_MAX;
      2: v = 0;
      3: v = -1;
      4: v = lim - 2 + int'($urandom_range(3));
      default: v = int'($urandom_range(2 ** CB - 1)) + COORD_MIN;
    endcase
    if (v > COORD_MAX) v = COORD_MAX;
    return v[CB-1:0];
  endfunction

  // End coordinate close to the start, so most lines stay short.
  function automatic logic signed [CB-1:0] coord_near(input int base);
    int span, v;
    span = ($urandom_range(29) == 0) ? 200 : 12;
    v = base + int'($urandom_range(2 * span)) - span;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[CB-1:0];
  endfunction

  // Random lines: mostly complete lines, plus stray advances and lines cut short.
  task automatic run_lines(input int target);
    int sent, n_adv;
    bit paused;
    line_item_t it;
    sent = 0;
    paused = 1'b0;
    while (sent < target) begin
      it = random_item(CMD_ADVANCE);
      case ($urandom_range(19))
        0, 1: begin
          send_item(it, 1'b0, no_pixel);
          sent++;
        end
        2, 3: begin
          it.cmd = CMD_LOAD;
          send_item(it, 1'b0, no_pixel);
          sent++;
          n_adv = $urandom_range(12);
          repeat (n_adv) begin
            send_item(random_item(CMD_ADVANCE), 1'b0, no_pixel);
            sent++;
          end
        end
        default: begin
          it.cmd = CMD_LOAD;
          it.sx = pick_coord(scr_width);
          it.sy = pick_coord(scr_height);
          it.ex = coord_near(it.sx);
          it.ey = coord_near(it.sy);
          send_item(it, 1'b0, no_pixel);
          sent++;
          while (line_busy) begin
            send_item(random_item(CMD_ADVANCE), 1'b0, no_pixel);
            sent++;
          end
        end
      endcase
      // Once per phase the sender waits for the result queue to run dry.
      if (!paused && sent >= target / 2) begin
        paused = 1'b1;
        drain();
      end
    end
  endtask

  // Main sequence: reset, register check, directed table, then random phases.
  initial begin
    int phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    check_reg(WIDTH_ADDR);
    check_reg(HEIGHT_ADDR);

    build_directed();
    foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].px);
    drain();

    for (phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: begin
          write_reg(WIDTH_ADDR, 2047);
          write_reg(HEIGHT_ADDR, 2047);
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        2: begin
          write_reg(WIDTH_ADDR, 1);
          write_reg(HEIGHT_ADDR, 1);
          send_gap_pct = 70;
          recv_stall_pct = 0;
        end
        3: begin
          // Zero width: nothing is visible.
          write_reg(WIDTH_ADDR, 0);
          write_reg(HEIGHT_ADDR, 37);
          send_gap_pct = 0;
          recv_stall_pct = 70;
        end
        4: begin
          write_reg(WIDTH_ADDR, 640);
          write_reg(HEIGHT_ADDR, 0);
          send_gap_pct = 14;
          recv_stall_pct = 14;
        end
        default: begin
          write_reg(WIDTH_ADDR, $urandom_range(2047, 1));
          write_reg(HEIGHT_ADDR, $urandom_range(2047, 1));
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      run_lines(PHASE_ITEMS);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
